@@ design/fcdma_pkg.sv @@
`default_nettype none

package fcdma_pkg;

  localparam int MAX_CHANNELS = 4;
  localparam int DEF_NUM_CHANNELS = 4;

  localparam int CMD_W = 2;
  localparam int CHAN_W = 2;
  localparam int REG_W = 4;
  localparam int BYTE_W = 8;
  localparam int ADDR_W = 16;
  localparam int COUNT_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic {
    KIND_READ = 1'b0,
    KIND_COPY = 1'b1
  } kind_t;

  typedef enum logic [REG_W-1:0] {
    REG_CONTROL   = 4'd0,
    REG_STATUS    = 4'd1,
    REG_COPIED_LO = 4'd2,
    REG_COPIED_HI = 4'd3,
    REG_UNUSED_4  = 4'd4,
    REG_UNUSED_5  = 4'd5,
    REG_UNUSED_6  = 4'd6,
    REG_UNUSED_7  = 4'd7,
    REG_DST_BANK  = 4'd8,
    REG_SRC_BANK  = 4'd9,
    REG_RELOAD_LO = 4'd10,
    REG_RELOAD_HI = 4'd11,
    REG_DST_LO    = 4'd12,
    REG_DST_HI    = 4'd13,
    REG_SRC_LO    = 4'd14,
    REG_SRC_HI    = 4'd15
  } reg_idx_t;

  localparam logic [BYTE_W-1:0] CTRL_WRITE_MASK = 8'h8F;
  localparam logic [BYTE_W-1:0] STATUS_COPYING = 8'h80;
  localparam logic [BYTE_W-1:0] UNMAPPED_BYTE = 8'hFF;

  // control register bit positions
  localparam int CTRL_ENABLE = 7;
  localparam int CTRL_CLEAR_COPIED = 4;
  localparam int CTRL_DST_FIXED = 3;
  localparam int CTRL_SRC_FIXED = 2;
  localparam int CTRL_NMI = 1;
  localparam int CTRL_IRQ = 0;

  typedef struct packed {
    logic [BYTE_W-1:0]  ctrl;
    logic               copying;
    logic [COUNT_W-1:0] copied;
    logic [COUNT_W-1:0] remain;
    logic [COUNT_W-1:0] reload;
    logic [ADDR_W-1:0]  dst_addr;
    logic [ADDR_W-1:0]  src_addr;
    logic [BYTE_W-1:0]  dst_bank;
    logic [BYTE_W-1:0]  src_bank;
  } chan_state_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAN_W-1:0] chan_id;
    logic [BYTE_W-1:0] read_data;
    logic [BYTE_W-1:0] src_bank;
    logic [ADDR_W-1:0] src_addr;
    logic [BYTE_W-1:0] dst_bank;
    logic [ADDR_W-1:0] dst_addr;
    logic              raise_nmi;
    logic              raise_irq;
  } result_t;

endpackage

`default_nettype wire

@@ design/fcdma_in_if.sv @@
`default_nettype none

interface fcdma_in_if
  import fcdma_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CHAN_W-1:0] channel;
  logic [REG_W-1:0]  reg_index;
  logic [BYTE_W-1:0] write_data;

  modport source (output valid, command, channel, reg_index, write_data, input ready);
  modport sink (input valid, command, channel, reg_index, write_data, output ready);
endinterface

`default_nettype wire

@@ design/fcdma_out_if.sv @@
`default_nettype none

interface fcdma_out_if
  import fcdma_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [CHAN_W-1:0] chan_id;
  logic [BYTE_W-1:0] read_data;
  logic [BYTE_W-1:0] src_bank;
  logic [ADDR_W-1:0] src_addr;
  logic [BYTE_W-1:0] dst_bank;
  logic [ADDR_W-1:0] dst_addr;
  logic              raise_nmi;
  logic              raise_irq;
  logic              last;

  modport source (
    output valid, kind, chan_id, read_data, src_bank, src_addr, dst_bank, dst_addr,
           raise_nmi, raise_irq, last,
    input  ready
  );
  modport sink (
    input  valid, kind, chan_id, read_data, src_bank, src_addr, dst_bank, dst_addr,
           raise_nmi, raise_irq, last,
    output ready
  );
endinterface

`default_nettype wire

@@ design/four_channel_dma_controller.sv @@
`default_nettype none

// Four-channel byte DMA sequencer with a 16-byte register window per channel.
// A register read, write or DMA tick is taken and all state is updated at the
// edge that accepts it; the results it causes land in a small result buffer,
// one slot per channel, and leave through the single output port at one per
// cycle while out_ch.ready is high, in channel order. A read gives one result
// and a write none, so those run at one transaction per cycle while the output
// is ready. A tick gives one copy request for every enabled, copying channel,
// at most NUM_CHANNELS (4), so the next transaction is taken once the buffer
// drains. The buffer's last slot can drain in the same cycle a new transaction
// enters. Copy requests carry the bank and address before the step; raise_nmi
// or raise_irq marks the request that ends a job if its NMI or IRQ bit is set.
module four_channel_dma_controller
  import fcdma_pkg::*;
#(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  wire          clk,
  input  wire          rst_n,
  fcdma_in_if.sink     in_ch,
  fcdma_out_if.source  out_ch
);

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CHAN_W:0] CH_LIMIT = (CHAN_W+1)'(NUM_CHANNELS);

  chan_state_t st_r   [NUM_CHANNELS];
  chan_state_t st_nxt [NUM_CHANNELS];
  result_t     res_r  [NUM_CHANNELS];
  result_t     res_nxt[NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] pend_r, pend_nxt;

  logic [CH_IDX_W-1:0] sel;
  logic                last_sel;
  logic                in_fire, out_fire;
  logic                ch_ok;
  logic [CH_IDX_W-1:0] idx;
  chan_state_t         cur;
  logic [BYTE_W-1:0]   rd_byte;
  logic [COUNT_W-1:0]  remain_dec;
  cmd_t                cmd;

  assign cmd   = cmd_t'(in_ch.command);
  assign ch_ok = {1'b0, in_ch.channel} < CH_LIMIT;
  assign idx   = in_ch.channel[CH_IDX_W-1:0];
  assign cur   = st_r[idx];

  // lowest-numbered pending slot goes out first
  always_comb begin
    sel = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (pend_r[i]) sel = CH_IDX_W'(i);
    end
  end

  assign last_sel = (pend_r & (pend_r - 1'b1)) == '0;

  assign out_ch.valid     = |pend_r;
  assign out_ch.kind      = res_r[sel].kind;
  assign out_ch.chan_id   = res_r[sel].chan_id;
  assign out_ch.read_data = res_r[sel].read_data;
  assign out_ch.src_bank  = res_r[sel].src_bank;
  assign out_ch.src_addr  = res_r[sel].src_addr;
  assign out_ch.dst_bank  = res_r[sel].dst_bank;
  assign out_ch.dst_addr  = res_r[sel].dst_addr;
  assign out_ch.raise_nmi = res_r[sel].raise_nmi;
  assign out_ch.raise_irq = res_r[sel].raise_irq;
  assign out_ch.last      = last_sel;

  assign out_fire    = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (pend_r == '0) || (out_ch.ready && last_sel);
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    unique case (reg_idx_t'(in_ch.reg_index))
      REG_CONTROL:   rd_byte = cur.ctrl;
      REG_STATUS:    rd_byte = cur.copying ? STATUS_COPYING : '0;
      REG_COPIED_LO: rd_byte = cur.copied[7:0];
      REG_COPIED_HI: rd_byte = cur.copied[15:8];
      REG_DST_BANK:  rd_byte = cur.dst_bank;
      REG_SRC_BANK:  rd_byte = cur.src_bank;
      REG_RELOAD_LO: rd_byte = cur.reload[7:0];
      REG_RELOAD_HI: rd_byte = cur.reload[15:8];
      REG_DST_LO:    rd_byte = cur.dst_addr[7:0];
      REG_DST_HI:    rd_byte = cur.dst_addr[15:8];
      REG_SRC_LO:    rd_byte = cur.src_addr[7:0];
      REG_SRC_HI:    rd_byte = cur.src_addr[15:8];
      default:       rd_byte = UNMAPPED_BYTE;
    endcase
    if (!ch_ok) rd_byte = UNMAPPED_BYTE;
  end

  always_comb begin
    st_nxt     = st_r;
    res_nxt    = res_r;
    pend_nxt   = pend_r;
    remain_dec = '0;
    if (out_fire) pend_nxt[sel] = 1'b0;
    if (in_fire) begin
      unique case (cmd)
        CMD_READ: begin
          res_nxt[0]           = '0;
          res_nxt[0].kind      = KIND_READ;
          res_nxt[0].chan_id   = in_ch.channel;
          res_nxt[0].read_data = rd_byte;
          pend_nxt[0]          = 1'b1;
        end
        CMD_WRITE: begin
          if (ch_ok) begin
            unique case (reg_idx_t'(in_ch.reg_index))
              REG_CONTROL: begin
                st_nxt[idx].ctrl = in_ch.write_data & CTRL_WRITE_MASK;
                if (in_ch.write_data[CTRL_CLEAR_COPIED]) st_nxt[idx].copied = '0;
                if (in_ch.write_data[CTRL_ENABLE]) begin
                  st_nxt[idx].remain  = cur.reload;
                  st_nxt[idx].copying = 1'b1;
                end
              end
              REG_DST_BANK: st_nxt[idx].dst_bank = in_ch.write_data;
              REG_SRC_BANK: st_nxt[idx].src_bank = in_ch.write_data;
              REG_RELOAD_LO: begin
                st_nxt[idx].reload = {cur.reload[15:8], in_ch.write_data};
                st_nxt[idx].remain = {cur.reload[15:8], in_ch.write_data};
              end
              REG_RELOAD_HI: begin
                st_nxt[idx].reload = {in_ch.write_data, cur.reload[7:0]};
                st_nxt[idx].remain = {in_ch.write_data, cur.reload[7:0]};
              end
              REG_DST_LO: st_nxt[idx].dst_addr = {cur.dst_addr[15:8], in_ch.write_data};
              REG_DST_HI: st_nxt[idx].dst_addr = {in_ch.write_data, cur.dst_addr[7:0]};
              REG_SRC_LO: st_nxt[idx].src_addr = {cur.src_addr[15:8], in_ch.write_data};
              REG_SRC_HI: st_nxt[idx].src_addr = {in_ch.write_data, cur.src_addr[7:0]};
              default: ;
            endcase
          end
        end
        CMD_TICK: begin
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (st_r[c].ctrl[CTRL_ENABLE] && st_r[c].copying) begin
              res_nxt[c]          = '0;
              res_nxt[c].kind     = KIND_COPY;
              res_nxt[c].chan_id  = CHAN_W'(c);
              res_nxt[c].src_bank = st_r[c].src_bank;
              res_nxt[c].src_addr = st_r[c].src_addr;
              res_nxt[c].dst_bank = st_r[c].dst_bank;
              res_nxt[c].dst_addr = st_r[c].dst_addr;
              pend_nxt[c]         = 1'b1;
              st_nxt[c].copied    = st_r[c].copied + 1'b1;
              if (!st_r[c].ctrl[CTRL_DST_FIXED]) st_nxt[c].dst_addr = st_r[c].dst_addr + 1'b1;
              if (!st_r[c].ctrl[CTRL_SRC_FIXED]) st_nxt[c].src_addr = st_r[c].src_addr + 1'b1;
              remain_dec        = st_r[c].remain - 1'b1;
              st_nxt[c].remain  = remain_dec;
              if (remain_dec == '0) begin
                // job done: stop and flag the interrupt, NMI wins over IRQ
                st_nxt[c].copying    = 1'b0;
                res_nxt[c].raise_nmi = st_r[c].ctrl[CTRL_NMI];
                res_nxt[c].raise_irq = !st_r[c].ctrl[CTRL_NMI] && st_r[c].ctrl[CTRL_IRQ];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) st_r[c] <= '0;
    end else begin
      pend_r <= pend_nxt;
      st_r   <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == '0 |-> in_ch.ready)
    else $error("input stalled with an empty result buffer");

  a_read_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && cmd == CMD_READ |=> $countones(pend_r) == 1 && out_ch.kind == KIND_READ)
    else $error("register read did not leave exactly one read result");

  a_write_none: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && cmd == CMD_WRITE |=> pend_r == '0)
    else $error("register write left a result pending");

  a_irq_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.raise_nmi && out_ch.raise_irq))
    else $error("NMI and IRQ raised together");

  a_read_no_int: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == KIND_READ |->
      !out_ch.raise_nmi && !out_ch.raise_irq && out_ch.last)
    else $error("read result carries interrupt or is not last");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top
  import fcdma_pkg::*;
;

  localparam int NUM_CH = 4;
  localparam int CYCLE_LIMIT = 50000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    result_t res;
    logic    last;
  } dma_result_t;

  logic clk;
  logic rst_n;

  fcdma_in_if  in_if ();
  fcdma_out_if out_if ();

  four_channel_dma_controller #(
    .NUM_CHANNELS(NUM_CH)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  chan_state_t chan_model[NUM_CH];
  dma_result_t pending_results[$];
  dma_result_t oldest_result;
  int          error_count;
  int          items_sent;
  int          cycle_count;
  int          hold_off_left;
  bit          gaps_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one accepted transaction to the channel model and queue what it emits.
  function automatic void predict_dma_results(cmd_t cmd, logic [CHAN_W-1:0] chan,
                                              reg_idx_t idx, logic [BYTE_W-1:0] data);
    dma_result_t       r;
    dma_result_t       copies[$];
    logic [BYTE_W-1:0] rd;
    r = '0;
    case (cmd)
      CMD_READ: begin
        rd = UNMAPPED_BYTE;
        if (chan < NUM_CH) begin
          case (idx)
            REG_CONTROL:   rd = chan_model[chan].ctrl;
            REG_STATUS:    rd = chan_model[chan].copying ? STATUS_COPYING : 8'h00;
            REG_COPIED_LO: rd = chan_model[chan].copied[7:0];
            REG_COPIED_HI: rd = chan_model[chan].copied[15:8];
            REG_DST_BANK:  rd = chan_model[chan].dst_bank;
            REG_SRC_BANK:  rd = chan_model[chan].src_bank;
            REG_RELOAD_LO: rd = chan_model[chan].reload[7:0];
            REG_RELOAD_HI: rd = chan_model[chan].reload[15:8];
            REG_DST_LO:    rd = chan_model[chan].dst_addr[7:0];
            REG_DST_HI:    rd = chan_model[chan].dst_addr[15:8];
            REG_SRC_LO:    rd = chan_model[chan].src_addr[7:0];
            REG_SRC_HI:    rd = chan_model[chan].src_addr[15:8];
            default:       rd = UNMAPPED_BYTE;
          endcase
        end
        r.res.kind = KIND_READ;
        r.res.chan_id = chan;
        r.res.read_data = rd;
        r.last = 1'b1;
        pending_results.push_back(r);
      end
      CMD_WRITE: begin
        if (chan < NUM_CH) begin
          case (idx)
            REG_CONTROL: begin
              chan_model[chan].ctrl = data & CTRL_WRITE_MASK;
              if (data[CTRL_CLEAR_COPIED]) chan_model[chan].copied = '0;
              if (data[CTRL_ENABLE]) begin
                chan_model[chan].remain = chan_model[chan].reload;
                chan_model[chan].copying = 1'b1;
              end
            end
            REG_DST_BANK: chan_model[chan].dst_bank = data;
            REG_SRC_BANK: chan_model[chan].src_bank = data;
            REG_RELOAD_LO: begin
              chan_model[chan].reload[7:0] = data;
              chan_model[chan].remain = chan_model[chan].reload;
            end
            REG_RELOAD_HI: begin
              chan_model[chan].reload[15:8] = data;
              chan_model[chan].remain = chan_model[chan].reload;
            end
            REG_DST_LO: chan_model[chan].dst_addr[7:0] = data;
            REG_DST_HI: chan_model[chan].dst_addr[15:8] = data;
            REG_SRC_LO: chan_model[chan].src_addr[7:0] = data;
            REG_SRC_HI: chan_model[chan].src_addr[15:8] = data;
            default: ;
          endcase
        end
      end
      CMD_TICK: begin
        for (int c = 0; c < NUM_CH; c++) begin
          if (!(chan_model[c].ctrl[CTRL_ENABLE] && chan_model[c].copying)) continue;
          r = '0;
          r.res.kind = KIND_COPY;
          r.res.chan_id = CHAN_W'(c);
          r.res.src_bank = chan_model[c].src_bank;
          r.res.src_addr = chan_model[c].src_addr;
          r.res.dst_bank = chan_model[c].dst_bank;
          r.res.dst_addr = chan_model[c].dst_addr;
          chan_model[c].copied = chan_model[c].copied + 1'b1;
          if (!chan_model[c].ctrl[CTRL_DST_FIXED])
            chan_model[c].dst_addr = chan_model[c].dst_addr + 1'b1;
          if (!chan_model[c].ctrl[CTRL_SRC_FIXED])
            chan_model[c].src_addr = chan_model[c].src_addr + 1'b1;
          chan_model[c].remain = chan_model[c].remain - 1'b1;
          if (chan_model[c].remain == '0) begin
            chan_model[c].copying = 1'b0;
            if (chan_model[c].ctrl[CTRL_NMI]) r.res.raise_nmi = 1'b1;
            else if (chan_model[c].ctrl[CTRL_IRQ]) r.res.raise_irq = 1'b1;
          end
          copies.push_back(r);
        end
        if (copies.size() > 0) copies[copies.size()-1].last = 1'b1;
        foreach (copies[i]) pending_results.push_back(copies[i]);
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(cmd_t cmd, logic [CHAN_W-1:0] chan, reg_idx_t idx,
                           logic [BYTE_W-1:0] data);
    while (gaps_on && $urandom_range(0, 99) < 10) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.command    <= cmd;
    in_if.channel    <= chan;
    in_if.reg_index  <= idx;
    in_if.write_data <= data;
    do @(posedge clk); while (!in_if.ready);
    predict_dma_results(cmd, chan, idx, data);
    items_sent++;
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Result side: random stalls, plus long hold-offs requested by the tests.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        out_if.ready <= 1'b0;
        hold_off_left--;
      end else if (gaps_on && $urandom_range(0, 99) < 10) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d chan %0d", out_if.kind, out_if.chan_id);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("kind", oldest_result.res.kind, out_if.kind);
        check_field("chan_id", oldest_result.res.chan_id, out_if.chan_id);
        check_field("read_data", oldest_result.res.read_data, out_if.read_data);
        check_field("src_bank", oldest_result.res.src_bank, out_if.src_bank);
        check_field("src_addr", oldest_result.res.src_addr, out_if.src_addr);
        check_field("dst_bank", oldest_result.res.dst_bank, out_if.dst_bank);
        check_field("dst_addr", oldest_result.res.dst_addr, out_if.dst_addr);
        check_field("raise_nmi", oldest_result.res.raise_nmi, out_if.raise_nmi);
        check_field("raise_irq", oldest_result.res.raise_irq, out_if.raise_irq);
        check_field("last", oldest_result.last, out_if.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Finish a short job on channel 0 with NMI taking priority over IRQ.
  task automatic test_job_end();
    send_item(CMD_WRITE, 2'd0, REG_RELOAD_LO, 8'h02);
    send_item(CMD_WRITE, 2'd0, REG_RELOAD_HI, 8'h00);
    send_item(CMD_WRITE, 2'd0, REG_SRC_HI, 8'hFF);
    send_item(CMD_WRITE, 2'd0, REG_SRC_LO, 8'hFF);
    send_item(CMD_WRITE, 2'd0, REG_DST_BANK, 8'hFF);
    send_item(CMD_WRITE, 2'd0, REG_CONTROL, 8'h97);
    send_item(CMD_TICK, 2'd0, REG_CONTROL, 8'h00);
    send_item(CMD_TICK, 2'd0, REG_CONTROL, 8'h00);
    // enabled, job done: the tick emits nothing
    send_item(CMD_TICK, 2'd0, REG_CONTROL, 8'h00);
    send_item(CMD_READ, 2'd0, REG_STATUS, 8'h00);
    send_item(CMD_READ, 2'd0, REG_COPIED_LO, 8'h00);
  endtask

  // Zero count, a count rewrite while running, then pause and resume on channel 1.
  task automatic test_paused_channel();
    send_item(CMD_WRITE, 2'd1, REG_CONTROL, 8'h88);
    send_item(CMD_TICK, 2'd3, REG_SRC_HI, 8'hFF);
    send_item(CMD_WRITE, 2'd1, REG_RELOAD_LO, 8'h01);
    send_item(CMD_WRITE, 2'd1, REG_CONTROL, 8'h08);
    send_item(CMD_TICK, 2'd1, REG_CONTROL, 8'h00);
    send_item(CMD_WRITE, 2'd1, REG_CONTROL, 8'h89);
    send_item(CMD_TICK, 2'd1, REG_CONTROL, 8'h00);
  endtask

  task automatic test_unmapped_regs();
    send_item(CMD_WRITE, 2'd3, REG_UNUSED_5, 8'hAB);
    send_item(CMD_READ, 2'd3, REG_UNUSED_5, 8'h00);
    send_item(CMD_WRITE, 2'd2, REG_STATUS, 8'hFF);
    send_item(CMD_READ, 2'd2, REG_STATUS, 8'h00);
    send_item(CMD_NONE, 2'd3, REG_SRC_HI, 8'hFF);
    send_item(CMD_READ, 2'd3, REG_UNUSED_7, 8'hFF);
    send_item(CMD_WRITE, 2'd0, REG_CONTROL, 8'h00);
  endtask

  // Hold the result side off while ticks keep coming, so the input stalls.
  task automatic test_back_pressure();
    for (int c = 0; c < NUM_CH; c++) begin
      send_item(CMD_WRITE, CHAN_W'(c), REG_RELOAD_LO, 8'($urandom_range(32, 255)));
      send_item(CMD_WRITE, CHAN_W'(c), REG_RELOAD_HI, 8'h00);
      send_item(CMD_WRITE, CHAN_W'(c), REG_CONTROL, 8'($urandom_range(0, 15)) | 8'h80);
    end
    hold_off_left = 60;
    repeat (12) send_item(CMD_TICK, CHAN_W'($urandom), reg_idx_t'($urandom), 8'($urandom));
    // park every channel: copying stays set, ticks skip it
    for (int c = 0; c < NUM_CH; c++) send_item(CMD_WRITE, CHAN_W'(c), REG_CONTROL, 8'h00);
  endtask

  task automatic test_random_traffic();
    logic [CHAN_W-1:0] ch;
    int                first;
    first = items_sent;
    while (items_sent - first < 150) begin
      ch = CHAN_W'($urandom);
      gaps_on = !((items_sent - first) >= 70 && (items_sent - first) < 120);
      if ($urandom_range(0, 3) != 0) begin
        // program a job, mostly with short counts
        send_item(CMD_WRITE, ch, REG_RELOAD_LO,
                  ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6)));
        send_item(CMD_WRITE, ch, REG_RELOAD_HI,
                  ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
        for (int r = REG_DST_BANK; r <= REG_SRC_HI; r++) begin
          if ($urandom_range(0, 1)) send_item(CMD_WRITE, ch, reg_idx_t'(r), 8'($urandom));
        end
        send_item(CMD_WRITE, ch, REG_CONTROL, 8'($urandom) | 8'h80);
      end else begin
        repeat ($urandom_range(1, 3))
          send_item(cmd_t'($urandom_range(0, 3)), CHAN_W'($urandom), reg_idx_t'($urandom),
                    8'($urandom));
      end
      repeat ($urandom_range(1, 6)) begin
        send_item(CMD_TICK, CHAN_W'($urandom), reg_idx_t'($urandom), 8'($urandom));
        if ($urandom_range(0, 2) == 0)
          send_item(CMD_READ, CHAN_W'($urandom), reg_idx_t'($urandom), 8'($urandom));
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    gaps_on = 1'b1;
    hold_off_left = 0;
    error_count = 0;
    items_sent = 0;
    cycle_count = 0;
    in_if.valid = 1'b0;
    in_if.command = CMD_NONE;
    in_if.channel = '0;
    in_if.reg_index = REG_CONTROL;
    in_if.write_data = '0;
    foreach (chan_model[i]) chan_model[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_job_end();
    test_paused_channel();
    test_unmapped_regs();
    test_back_pressure();
    test_random_traffic();

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ four_channel_dma_controller.f @@
design/fcdma_pkg.sv
design/fcdma_in_if.sv
design/fcdma_out_if.sv
design/four_channel_dma_controller.sv
test/tb_top.sv
